FILE: rtl/pet_subset_bin_index_mapper_core_defines.svh
// Assertion macros for the checker file of the bin index mapper.
// Needs a clk and an active-high synchronous rst in the scope of each use.
`ifndef PET_SUBSET_BIN_INDEX_MAPPER_CORE_DEFINES_SVH
`define PET_SUBSET_BIN_INDEX_MAPPER_CORE_DEFINES_SVH

// Checked only outside reset.
`define PSBIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked in every cycle, reset included.
`define PSBIM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/psbim_pkg.sv
// Widths, register indexes and the derived configuration bundle of the bin index mapper.
// No dependencies.
package psbim_pkg;

  localparam int Z_W        = 14;
  localparam int PHI_W      = 13;
  localparam int R_W        = 13;
  localparam int NS_W       = 13;
  localparam int SI_W       = 12;
  localparam int PLANE_W    = 26;
  localparam int PHR_W      = 26;
  localparam int SIZE_W     = 40;
  localparam int ZQ_W       = 14;
  localparam int LPHI_W     = 13;
  localparam int PHI_FULL_W = 27;
  localparam int PROD_W     = 40;
  localparam int SUM_W      = 42;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_Z        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PHI      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_R        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSET_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSET_INDEX = 3'd4;

  typedef struct packed {
    logic [Z_W-1:0]     num_z;
    logic [PHI_W-1:0]   num_phi;
    logic [R_W-1:0]     num_r;
    logic [NS_W-1:0]    subset_count;
    logic [SI_W-1:0]    subset_index;
    logic [PLANE_W-1:0] plane;
    logic [PHR_W-1:0]   phr;
    logic [SIZE_W-1:0]  size;
    logic               busy;
  } cfg_t;

endpackage

FILE: rtl/psbim_if.sv
// Valid/ready channel interfaces for the position input and the bin index output.
// No dependencies.
interface psbim_in_if #(parameter int INDEX_WIDTH = 37) ();
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] position;
  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface psbim_out_if #(parameter int INDEX_WIDTH = 37) ();
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] bin_index;
  logic                   out_of_range;
  modport source (output valid, output bin_index, output out_of_range, input ready);
  modport sink (input valid, input bin_index, input out_of_range, output ready);
endinterface

FILE: rtl/psbim_cfg.sv
// Configuration registers and the sequencer that derives angles per subset, plane and size.
// Depends on psbim_pkg.
module psbim_cfg import psbim_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_APS   = 3'd3;
  localparam logic [2:0] ST_PLANE = 3'd4;
  localparam logic [2:0] ST_SIZE  = 3'd5;
  localparam logic [3:0] DIV_LAST = 4'(PHI_W - 1);

  logic [Z_W-1:0]     num_z;
  logic [PHI_W-1:0]   num_phi;
  logic [R_W-1:0]     num_r;
  logic [NS_W-1:0]    subset_count;
  logic [SI_W-1:0]    subset_index;
  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [3:0]         cnt;
  logic [PHI_W-1:0]   dq;
  logic [PHI_W-1:0]   rem;
  logic [PHI_W-1:0]   aps;
  logic [PLANE_W-1:0] plane;
  logic [PHR_W-1:0]   phr;
  logic [SIZE_W-1:0]  size;
  logic [PHI_W:0]     trial;
  logic [PHI_W:0]     diff;
  logic               take;
  logic               si_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_z        <= Z_W'(1);
      num_phi      <= PHI_W'(1);
      num_r        <= R_W'(1);
      subset_count <= NS_W'(1);
      subset_index <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_Z:        num_z        <= cfg_data[Z_W-1:0];
        REG_NUM_PHI:      num_phi      <= cfg_data[PHI_W-1:0];
        REG_NUM_R:        num_r        <= cfg_data[R_W-1:0];
        REG_SUBSET_COUNT: subset_count <= cfg_data[NS_W-1:0];
        REG_SUBSET_INDEX: subset_index <= cfg_data[SI_W-1:0];
        default: ;
      endcase
    end
  end

  // One quotient bit of num_phi / subset_count per cycle.
  always_comb begin
    trial = {rem, dq[PHI_W-1]};
    take  = trial >= {1'b0, subset_count};
    diff  = trial - {1'b0, subset_count};
    si_lt = {1'b0, subset_index} < rem;
  end

  always_comb begin
    case (state)
      ST_IDLE:  state_next = ST_IDLE;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV:   state_next = (cnt == DIV_LAST) ? ST_APS : ST_DIV;
      ST_APS:   state_next = ST_PLANE;
      ST_PLANE: state_next = ST_SIZE;
      ST_SIZE:  state_next = ST_IDLE;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else if (cfg_write) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        dq  <= num_phi;
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        dq  <= {dq[PHI_W-2:0], take};
        rem <= take ? diff[PHI_W-1:0] : trial[PHI_W-1:0];
        cnt <= cnt + 4'd1;
      end
      ST_APS: begin
        aps <= (subset_count == '0) ? '0 : dq + {{(PHI_W-1){1'b0}}, si_lt};
      end
      ST_PLANE: begin
        plane <= PLANE_W'(num_r) * PLANE_W'(aps);
        phr   <= PHR_W'(num_phi) * PHR_W'(num_r);
      end
      ST_SIZE: begin
        size <= SIZE_W'(plane) * SIZE_W'(num_z);
      end
      default: ;
    endcase
  end

  assign cfg.num_z        = num_z;
  assign cfg.num_phi      = num_phi;
  assign cfg.num_r        = num_r;
  assign cfg.subset_count = subset_count;
  assign cfg.subset_index = subset_index;
  assign cfg.plane        = plane;
  assign cfg.phr          = phr;
  assign cfg.size         = size;
  assign cfg.busy         = state != ST_IDLE;

endmodule

FILE: rtl/psbim_div_pipe.sv
// Pipelined restoring divider with a fixed divisor, one quotient bit per stage.
// No dependencies.
module psbim_div_pipe #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 26,
  parameter int Q_W    = 14,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [Q_W-1:0]    quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W-1:0]  rem_s  [1:Q_W];
  logic [Q_W-1:0]    q_s    [1:Q_W];
  logic [SIDE_W-1:0] side_s [1:Q_W];
  logic              vld_s  [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [NUM_W-1:0]  rem_cur;
    logic [Q_W-1:0]    q_cur;
    logic [SIDE_W-1:0] side_cur;
    logic              vld_cur;
    logic [NUM_W-1:0]  dsh;
    logic              take;
    logic [Q_W-1:0]    q_new;

    if (k == 0) begin : g_first
      assign rem_cur  = num;
      assign q_cur    = '0;
      assign side_cur = side_in;
      assign vld_cur  = in_vld;
    end else begin : g_rest
      assign rem_cur  = rem_s[k];
      assign q_cur    = q_s[k];
      assign side_cur = side_s[k];
      assign vld_cur  = vld_s[k];
    end

    always_comb begin
      dsh      = NUM_W'(den) << B;
      take     = rem_cur >= dsh;
      q_new    = q_cur;
      q_new[B] = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= take ? rem_cur - dsh : rem_cur;
        q_s[k+1]    <= q_new;
        side_s[k+1] <= side_cur;
      end
    end
  end

  assign out_vld  = vld_s[Q_W];
  assign quo      = q_s[Q_W];
  assign rem      = rem_s[Q_W][DEN_W-1:0];
  assign side_out = side_s[Q_W];

endmodule

FILE: rtl/pet_subset_bin_index_mapper_core.sv
// Maps a position within one interleaved angular subset of a z/phi/r sinogram to its
// global bin index. Takes one position beat per cycle unless the output is stalled or
// the configuration is busy. One input register, 14 z quotient stages, 13 local phi
// quotient stages, two multiplier stages and the output register; a stalled output
// stops them all. After reset and after each configuration write the input is held off
// while the angles per subset (bit-serial divider), the plane and the subset size are
// derived. Depends on psbim_pkg, psbim_if, psbim_cfg and psbim_div_pipe.
module pet_subset_bin_index_mapper_core import psbim_pkg::*; #(
  parameter int INDEX_WIDTH = 37
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  psbim_in_if.sink              request,
  psbim_out_if.source           result
);

  localparam int CMP_W = (INDEX_WIDTH > SIZE_W) ? INDEX_WIDTH : SIZE_W;

  cfg_t                   cfg;
  logic                   en;
  logic                   acc;
  logic                   vld0;
  logic [INDEX_WIDTH-1:0] pos0;
  logic                   oor0;
  logic                   vld1;
  logic [ZQ_W-1:0]        z1;
  logic [PLANE_W-1:0]     rem1;
  logic                   oor1;
  logic                   vld2;
  logic [LPHI_W-1:0]      lphi2;
  logic [R_W-1:0]         r2;
  logic [ZQ_W:0]          side2;
  logic                   vld3;
  logic [PROD_W-1:0]      zp3;
  logic [PHI_FULL_W-1:0]  phi3;
  logic [R_W-1:0]         r3;
  logic                   oor3;
  logic                   vld4;
  logic [PROD_W-1:0]      zp4;
  logic [PROD_W-1:0]      u4;
  logic [R_W-1:0]         r4;
  logic                   oor4;
  logic [SUM_W-1:0]       sum4;

  psbim_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign en            = !result.valid || result.ready;
  assign request.ready = en && !cfg.busy;
  assign acc           = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos0 <= request.position;
    end
  end

  assign oor0 = CMP_W'(pos0) >= CMP_W'(cfg.size);

  psbim_div_pipe #(
    .NUM_W  (SIZE_W),
    .DEN_W  (PLANE_W),
    .Q_W    (ZQ_W),
    .SIDE_W (1)
  ) u_div_z (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld0),
    .num      (SIZE_W'(pos0)),
    .den      (cfg.plane),
    .side_in  (oor0),
    .out_vld  (vld1),
    .quo      (z1),
    .rem      (rem1),
    .side_out (oor1)
  );

  psbim_div_pipe #(
    .NUM_W  (PLANE_W),
    .DEN_W  (R_W),
    .Q_W    (LPHI_W),
    .SIDE_W (ZQ_W + 1)
  ) u_div_phi (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld1),
    .num      (rem1),
    .den      (cfg.num_r),
    .side_in  ({oor1, z1}),
    .out_vld  (vld2),
    .quo      (lphi2),
    .rem      (r2),
    .side_out (side2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3          <= 1'b0;
      vld4          <= 1'b0;
      result.valid  <= 1'b0;
    end else if (en) begin
      vld3          <= vld2;
      vld4          <= vld3;
      result.valid  <= vld4;
    end
  end

  assign sum4 = SUM_W'(zp4) + SUM_W'(u4) + SUM_W'(r4);

  always_ff @(posedge clk) begin
    if (en) begin
      zp3  <= PROD_W'(side2[ZQ_W-1:0]) * PROD_W'(cfg.phr);
      phi3 <= PHI_FULL_W'(cfg.subset_count) * PHI_FULL_W'(lphi2)
              + PHI_FULL_W'(cfg.subset_index);
      r3   <= r2;
      oor3 <= side2[ZQ_W];
      zp4  <= zp3;
      u4   <= PROD_W'(phi3) * PROD_W'(cfg.num_r);
      r4   <= r3;
      oor4 <= oor3;
      result.bin_index    <= oor4 ? '0 : INDEX_WIDTH'(sum4);
      result.out_of_range <= oor4;
    end
  end

endmodule

FILE: rtl/psbim_checker.sv
// Port-level checks of the bin index mapper, bound to the top level.
// Depends on the defines header and pet_subset_bin_index_mapper_core.
`include "pet_subset_bin_index_mapper_core_defines.svh"

module psbim_checker #(
  parameter int INDEX_WIDTH = 37
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_write,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_of_range,
  input logic [INDEX_WIDTH-1:0] bin_index
);

  `PSBIM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output beat dropped")
  `PSBIM_ASSERT(a_oor_zero, out_valid && out_of_range |-> bin_index == '0, "nonzero index")
  `PSBIM_ASSERT(a_cfg_busy, cfg_write |=> !in_ready, "input taken during recompute")
  `PSBIM_ASSERT_ALWAYS(a_rst_quiet, rst |=> !out_valid && !in_ready, "active after reset")

endmodule

bind pet_subset_bin_index_mapper_core psbim_checker #(
  .INDEX_WIDTH (INDEX_WIDTH)
) u_psbim_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_write    (cfg_write),
  .in_ready     (request.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_of_range (result.out_of_range),
  .bin_index    (result.bin_index)
);

FILE: tb/pet_subset_bin_index_mapper_core_tb.sv
// Testbench for the subset bin index mapper: drives positions under several register
// settings and checks each bin index against a predictor of its own.
// Depends on psbim_pkg, psbim_if and pet_subset_bin_index_mapper_core.
`timescale 1ns / 1ps

module pet_subset_bin_index_mapper_core_tb import psbim_pkg::*; ();

  localparam int IW = 37;
  localparam longint unsigned IDX_MASK = (64'd1 << IW) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic [IW-1:0] bin_index;
    logic          out_of_range;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NUM_Z;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  psbim_in_if #(.INDEX_WIDTH(IW)) request ();
  psbim_out_if #(.INDEX_WIDTH(IW)) result ();

  pet_subset_bin_index_mapper_core #(.INDEX_WIDTH(IW)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .request(request),
    .result(result)
  );

  always #5 clk = ~clk;

  logic [Z_W-1:0] m_num_z;
  logic [PHI_W-1:0] m_num_phi;
  logic [R_W-1:0] m_num_r;
  logic [NS_W-1:0] m_subset_count;
  logic [SI_W-1:0] m_subset_index;

  bin_result_t expected_bins[$];
  int errors = 0;
  int mismatches = 0;
  int max_send_gap = 8;
  int max_stall = 8;
  bit result_fire = 1'b0;
  int stall_left = 0;

  initial begin
    request.valid = 1'b0;
    request.position = '0;
    result.ready = 1'b0;
  end

  function automatic longint unsigned subset_size();
    longint unsigned aps;
    if (m_subset_count == 0) return 0;
    aps = 64'(m_num_phi) / 64'(m_subset_count);
    if (64'(m_subset_index) + aps * 64'(m_subset_count) < 64'(m_num_phi)) aps++;
    return 64'(m_num_r) * aps * 64'(m_num_z);
  endfunction

  function automatic bin_result_t map_position(logic [IW-1:0] pos);
    bin_result_t res;
    longint unsigned plane, size, z, rem, lphi, r, phi;
    plane = (m_num_z == 0) ? 64'd0 : subset_size() / 64'(m_num_z);
    size = subset_size();
    if (64'(pos) >= size || plane == 0 || m_num_r == 0) begin
      res.bin_index = '0;
      res.out_of_range = 1'b1;
      return res;
    end
    z = 64'(pos) / plane;
    rem = 64'(pos) % plane;
    lphi = rem / 64'(m_num_r);
    r = rem % 64'(m_num_r);
    phi = 64'(m_subset_count) * lphi + 64'(m_subset_index);
    res.bin_index = IW'((z * 64'(m_num_phi) * 64'(m_num_r) + phi * 64'(m_num_r) + r)
                        & IDX_MASK);
    res.out_of_range = 1'b0;
    return res;
  endfunction

  // Beats are sampled on the falling edge, away from the rising edge that drives them.
  always @(negedge clk) begin
    bin_result_t want;
    result_fire = result.valid && result.ready && !rst;
    if (result_fire) begin
      if (expected_bins.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected beat: bin_index=%0d out_of_range=%0b",
                   result.bin_index, result.out_of_range);
      end else begin
        want = expected_bins.pop_front();
        if (want.bin_index !== result.bin_index || want.out_of_range !== result.out_of_range)
        begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected bin_index=%0d oor=%0b, got bin_index=%0d oor=%0b",
                     want.bin_index, want.out_of_range, result.bin_index,
                     result.out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result.ready <= 1'b0;
    end else if (result_fire || !result.ready) begin
      stall_left = $urandom_range(0, max_stall);
      result.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_position(logic [IW-1:0] pos);
    int gap;
    gap = $urandom_range(0, max_send_gap);
    if (gap > 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request.valid <= 1'b1;
    request.position <= pos;
    forever begin
      @(negedge clk);
      if (request.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    expected_bins.push_back(map_position(pos));
  endtask

  task automatic drain();
    request.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_NUM_Z:        m_num_z = data[Z_W-1:0];
      REG_NUM_PHI:      m_num_phi = data[PHI_W-1:0];
      REG_NUM_R:        m_num_r = data[R_W-1:0];
      REG_SUBSET_COUNT: m_subset_count = data[NS_W-1:0];
      REG_SUBSET_INDEX: m_subset_index = data[SI_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_geometry(int z, int phi, int r, int ns, int si);
    write_reg(REG_NUM_Z, CFG_DATA_W'(z));
    write_reg(REG_NUM_PHI, CFG_DATA_W'(phi));
    write_reg(REG_NUM_R, CFG_DATA_W'(r));
    write_reg(REG_SUBSET_COUNT, CFG_DATA_W'(ns));
    write_reg(REG_SUBSET_INDEX, CFG_DATA_W'(si));
  endtask

  function automatic logic [IW-1:0] pick_position();
    longint unsigned size, raw;
    int sel;
    size = subset_size();
    raw = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (size == 0 || sel < 6) return raw[IW-1:0];
    if (sel < 9) return size[IW-1:0];
    if (sel < 12) return IW'(size - 1);
    if (sel < 16) return IW'((size + raw % (size + 1)) & IDX_MASK);
    return IW'(raw % size);
  endfunction

  task automatic test_reset_defaults();
    send_position('0);
    send_position(IW'(1));
    send_position(IW'(2));
    send_position({IW{1'b1}});
    drain();
  endtask

  task automatic test_extreme_geometry();
    set_geometry(8192, 4096, 4096, 1, 0);
    send_position('0);
    send_position(IW'(subset_size() - 1));
    send_position(IW'(subset_size()));
    send_position({IW{1'b1}});
    drain();
    set_geometry(16383, 8191, 8191, 1, 0);
    send_position(IW'(subset_size() - 1));
    send_position(37'h15_5555_5555);
    send_position(37'h0A_AAAA_AAAA);
    drain();
    set_geometry(8192, 4096, 4096, 4096, 4095);
    send_position('0);
    send_position(IW'(8191));
    send_position(IW'(8192));
    drain();
  endtask

  task automatic test_zero_counts();
    set_geometry(0, 4, 4, 2, 1);
    send_position('0);
    drain();
    set_geometry(4, 0, 4, 2, 1);
    send_position('0);
    drain();
    set_geometry(4, 4, 0, 2, 1);
    send_position('0);
    drain();
    set_geometry(4, 4, 4, 0, 1);
    send_position('0);
    drain();
  endtask

  task automatic test_subset_beyond_count();
    set_geometry(3, 10, 5, 3, 7);
    send_position('0);
    send_position(IW'(subset_size() - 1));
    send_position(IW'(subset_size()));
    drain();
    write_reg(REG_UNMAPPED, 14'h3FFF);
    write_reg(REG_SUBSET_INDEX, CFG_DATA_W'(4095));
    send_position('0);
    send_position(IW'(4));
    drain();
  endtask

  task automatic test_random_streams(int total);
    int sent;
    sent = 0;
    while (sent < total) begin
      int ns, burst;
      ns = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0: set_geometry($urandom_range(0, 16383), $urandom_range(0, 8191),
                        $urandom_range(0, 8191), $urandom_range(0, 8191),
                        $urandom_range(0, 4095));
        1: set_geometry($urandom_range(1, 8), $urandom_range(1, 64), $urandom_range(1, 64),
                        ns, $urandom_range(ns, 4095));
        default: set_geometry($urandom_range(1, 8), $urandom_range(1, 64),
                              $urandom_range(1, 64), ns, $urandom_range(0, ns - 1));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        max_send_gap = 0;
        max_stall = 0;
      end else begin
        max_send_gap = 8;
        max_stall = 8;
      end
      burst = $urandom_range(20, 80);
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 49) == 0) drain();
        send_position(pick_position());
      end
      sent += burst;
      drain();
    end
  endtask

  initial begin
    m_num_z = Z_W'(1);
    m_num_phi = PHI_W'(1);
    m_num_r = R_W'(1);
    m_subset_count = NS_W'(1);
    m_subset_index = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_geometry();
    test_zero_counts();
    test_subset_beyond_count();
    test_random_streams(1700);
    request.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
